[rtl/stpc_pkg.sv]
// Shared constants, types and table functions of the sinusoid-tracking controller.
`default_nettype none
package stpc_pkg;

    // Phase accumulator width and cosine table address width.
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TBL_N           = 1 << TABLE_ADDR_BITS;

    // Field and port widths.
    localparam int FB_W       = 10;
    localparam int DRIVE_W    = 8;
    localparam int TGT_W      = 11;
    localparam int POS_W      = 12;
    localparam int ERR_W      = 13;
    localparam int GAIN_W     = 10;
    localparam int PROD_W     = TGT_W + GAIN_W;
    localparam int GAIN_FRAC  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM      = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] RST_PHASE_STEP = 32'd10737418;
    localparam logic [GAIN_W-1:0]     RST_GAIN       = 10'd51;
    localparam logic [DRIVE_W-1:0]    RST_MAX_PWM    = 8'd127;

    // Position scale raw*1800/675 equals floor(raw*8/3); the divide by three is a
    // reciprocal multiply that stays exact for every 13-bit dividend.
    localparam int SCALE_IN_W  = FB_W + 3;
    localparam int SCALE_MUL_W = 16;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 16'd43691;
    localparam int SCALE_SHIFT = 17;
    localparam int SCALE_PROD_W = SCALE_IN_W + SCALE_MUL_W;

    localparam logic [TGT_W-1:0] TGT_MAX = 11'd1800;

    typedef logic [PHASE_BITS-1:0]      t_phase;
    typedef logic [TABLE_ADDR_BITS-1:0] t_taddr;
    typedef logic [TGT_W-1:0]           t_target;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Cut or zero-extend a 32-bit register write to the accumulator width.
    function automatic t_phase cfg_to_phase(logic [CFG_DATA_W-1:0] d);
        t_phase r;
        for (int i = 0; i < PHASE_BITS; i++) begin
            r[i] = (i < CFG_DATA_W) ? d[i % CFG_DATA_W] : 1'b0;
        end
        return r;
    endfunction

    // Truncating Q30 Taylor series: sine when odd is set, cosine otherwise.
    function automatic logic [63:0] taylor_q30(logic [63:0] x, logic odd);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        x2   = (x * x) >> 30;
        term = odd ? x : Q30_ONE;
        pos  = term;
        neg  = 64'd0;
        if (odd) begin
            term = ((term * x2) >> 30) / 6;   neg = neg + term;
            term = ((term * x2) >> 30) / 20;  pos = pos + term;
            term = ((term * x2) >> 30) / 42;  neg = neg + term;
            term = ((term * x2) >> 30) / 72;  pos = pos + term;
            term = ((term * x2) >> 30) / 110; neg = neg + term;
            term = ((term * x2) >> 30) / 156; pos = pos + term;
        end else begin
            term = ((term * x2) >> 30) / 2;   neg = neg + term;
            term = ((term * x2) >> 30) / 12;  pos = pos + term;
            term = ((term * x2) >> 30) / 30;  neg = neg + term;
            term = ((term * x2) >> 30) / 56;  pos = pos + term;
            term = ((term * x2) >> 30) / 90;  neg = neg + term;
            term = ((term * x2) >> 30) / 132; pos = pos + term;
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    // Table entry k: floor-ish 900*(1-cos(2*pi*k/N)), folded to one octant.
    function automatic t_target rom_entry(int k);
        int          m;
        logic        negc;
        logic        use_sin;
        logic [63:0] x;
        logic [63:0] c;
        logic [63:0] v;
        m       = k;
        negc    = 1'b0;
        use_sin = 1'b0;
        if (m > TBL_N / 2) m = TBL_N - m;
        if (m > TBL_N / 4) begin
            m    = TBL_N / 2 - m;
            negc = 1'b1;
        end
        if (m > TBL_N / 8) begin
            m       = TBL_N / 4 - m;
            use_sin = 1'b1;
        end
        x = (64'(m) * TWO_PI_Q30) >> TABLE_ADDR_BITS;
        c = taylor_q30(x, use_sin);
        if (negc) begin
            v = (Q30_ONE + c) * 64'd900;
        end else if (Q30_ONE > c) begin
            v = (Q30_ONE - c) * 64'd900;
        end else begin
            v = 64'd0;
        end
        v = (v + (64'd1 << 14)) >> 30;
        if (v > 64'(TGT_MAX)) v = 64'(TGT_MAX);
        return v[TGT_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/sinusoid_tracking_p_controller_core.sv]
// Top level: DDS cosine target, scaled feedback and clamped proportional drive.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_feedback_raw
//   result    out        o_valid / i_stall    o_drive, o_target_pos, o_pos_error
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is not stalled; the result is taken from stage 3.
// Stage 1 reads the cosine ROM and scales the feedback, stage 2 forms the error and
// the gain product, stage 3 clamps into the output register.
// Reset is synchronous; it clears the accumulator, phase offset and all valid bits.
// A stalled output holds its item; earlier stages keep filling until the pipe is full.
`default_nettype none
module sinusoid_tracking_p_controller_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [stpc_pkg::FB_W-1:0]              i_feedback_raw,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [stpc_pkg::DRIVE_W-1:0]                o_drive,
    output logic [stpc_pkg::TGT_W-1:0]                  o_target_pos,
    output logic signed [stpc_pkg::ERR_W-1:0]           o_pos_error,
    input  wire logic                                   i_cfg_we,
    input  wire logic [stpc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [stpc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import stpc_pkg::*;

    // Configuration and phase state.
    t_phase              r_phase_step;
    t_phase              r_phase_offset;
    t_phase              r_phase_acc;
    logic [GAIN_W-1:0]   r_gain;
    logic [DRIVE_W-1:0]  r_max_pwm;

    // Pipeline registers.
    logic                r1_vld;
    t_target             r1_target;
    logic [POS_W-1:0]    r1_pos;
    logic                r2_vld;
    t_target             r2_target;
    logic signed [ERR_W-1:0] r2_err;
    logic [PROD_W-1:0]   r2_prod;
    logic                r_out_vld;
    logic [DRIVE_W-1:0]  r_drive;
    t_target             r_target;
    logic signed [ERR_W-1:0] r_err;

    // Constant cosine table.
    t_target             w_rom [TBL_N];

    logic                en1;
    logic                en2;
    logic                en3;
    logic                acc;
    t_phase              n_phase_acc;
    t_phase              phase_p;
    t_taddr              rom_addr;
    logic [SCALE_PROD_W-1:0] scale_prod;
    logic [POS_W-1:0]    n_pos;
    logic signed [ERR_W-1:0] n_err;
    logic [TGT_W-1:0]    err_pos;
    logic [PROD_W-1:0]   n_prod;
    logic [PROD_W-GAIN_FRAC-1:0] prod_q;
    logic [DRIVE_W-1:0]  n_drive;

    for (genvar g = 0; g < TBL_N; g++) begin : g_rom
        assign w_rom[g] = rom_entry(g);
    end

    // Each stage moves when the next one is empty or moving.
    assign en3     = !r_out_vld || !i_stall;
    assign en2     = !r2_vld || en3;
    assign en1     = !r1_vld || en2;
    assign o_stall = !en1;
    assign acc     = i_valid && en1;

    assign phase_p     = r_phase_acc + r_phase_offset;
    assign rom_addr    = phase_p[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign n_phase_acc = r_phase_acc + r_phase_step;

    assign scale_prod = {i_feedback_raw, 3'b000} * SCALE_MUL;
    assign n_pos      = scale_prod[SCALE_SHIFT +: POS_W];

    assign n_err   = $signed({2'b00, r1_target}) - $signed({1'b0, r1_pos});
    // Only a positive error drives; its magnitude never exceeds the target range.
    assign err_pos = (!n_err[ERR_W-1] && (n_err != '0)) ? n_err[TGT_W-1:0] : '0;
    assign n_prod  = err_pos * r_gain;

    assign prod_q  = r2_prod[PROD_W-1:GAIN_FRAC];
    assign n_drive = (prod_q > {{(PROD_W-GAIN_FRAC-DRIVE_W){1'b0}}, r_max_pwm}) ?
                     r_max_pwm : prod_q[DRIVE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= cfg_to_phase(RST_PHASE_STEP);
            r_phase_offset <= '0;
            r_gain         <= RST_GAIN;
            r_max_pwm      <= RST_MAX_PWM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_STEP: begin
                    r_phase_step <= cfg_to_phase(i_cfg_data);
                end
                REG_PHASE_OFFSET: begin
                    r_phase_offset <= cfg_to_phase(i_cfg_data);
                end
                REG_GAIN: begin
                    r_gain <= i_cfg_data[GAIN_W-1:0];
                end
                REG_MAX_PWM: begin
                    r_max_pwm <= i_cfg_data[DRIVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (acc) begin
                r_phase_acc <= n_phase_acc;
            end
            if (en1) begin
                r1_vld <= i_valid;
            end
            if (en2) begin
                r2_vld <= r1_vld;
            end
            if (en3) begin
                r_out_vld <= r2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_target <= w_rom[rom_addr];
            r1_pos    <= n_pos;
        end
        if (en2 && r1_vld) begin
            r2_target <= r1_target;
            r2_err    <= n_err;
            r2_prod   <= n_prod;
        end
        if (en3 && r2_vld) begin
            r_target <= r2_target;
            r_err    <= r2_err;
            r_drive  <= n_drive;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_drive      = r_drive;
    assign o_target_pos = r_target;
    assign o_pos_error  = r_err;

endmodule
`default_nettype wire

[rtl/stpc_checker.sv]
// Port-level checks of the controller core, bound to its top level.
`default_nettype none
module stpc_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   o_valid,
    input  wire logic                                   i_stall,
    input  wire logic [stpc_pkg::DRIVE_W-1:0]           o_drive,
    input  wire logic [stpc_pkg::TGT_W-1:0]             o_target_pos,
    input  wire logic signed [stpc_pkg::ERR_W-1:0]      o_pos_error
);
    import stpc_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled item stays put with its whole payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive) && $stable(o_target_pos)
            && $stable(o_pos_error))
        else $error("stalled result changed");

    // The target never leaves the table range.
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_target_pos <= TGT_MAX)
        else $error("target above range");

    // Drive only flows for a positive error.
    a_drive_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_drive != '0) |-> (o_pos_error > 0))
        else $error("drive without positive error");

endmodule

bind sinusoid_tracking_p_controller_core stpc_checker u_stpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_drive      (o_drive),
    .o_target_pos (o_target_pos),
    .o_pos_error  (o_pos_error)
);
`default_nettype wire
